// ===== src/sss_pkg.sv =====
// Shared types, constants and coil tables for the stepper step sequencer.
// No dependencies; used by sss_step_logic and stepper_step_sequencer.
`timescale 1ns / 1ps

package sss_pkg;

    // Widths of the tick timer and of the remaining step count
    localparam int TIMER_WIDTH = 26;
    localparam int COUNT_WIDTH = 31;

    // Fixed field widths
    localparam int PERIOD_WIDTH = 26;
    localparam int POS_WIDTH    = 16;
    localparam int MOVE_WIDTH   = 32;
    localparam int COIL_WIDTH   = 4;
    localparam int MODE_WIDTH   = 2;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 26;
    localparam int OUT_WIDTH      = 24;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEPS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_MODE    = 2'd2;

    // Drive modes
    localparam logic [MODE_WIDTH-1:0] MODE_DRIVER    = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_TWO_WIRE  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_FOUR_WIRE = 2'd2;

    // Input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Reset value of steps_per_rev
    localparam logic [POS_WIDTH-1:0] SPR_RESET = 16'd200;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] step_period;
        logic [POS_WIDTH-1:0]    steps_per_rev;
        logic [MODE_WIDTH-1:0]   drive_mode;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] elapsed;
        logic [COUNT_WIDTH-1:0] remaining;
        logic [POS_WIDTH-1:0]   position;
        logic                   direction;   // 1 forward, 0 reverse
        logic                   was_running;
        logic [COIL_WIDTH-1:0]  coils;
        logic                   dir_line;
    } state_t;

    typedef struct packed {
        logic [POS_WIDTH-1:0]  position;
        logic                  busy_res;
        logic                  done_res;
        logic                  step_pulse;
        logic                  dir_line;
        logic [COIL_WIDTH-1:0] coil_lines;
    } result_t;

    // Two-wire coil sequence by position mod 4
    function automatic logic [COIL_WIDTH-1:0] two_wire_coils(input logic [1:0] q);
        logic [COIL_WIDTH-1:0] c;
        case (q)
            2'd0:    c = 4'd2;
            2'd1:    c = 4'd3;
            2'd2:    c = 4'd1;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // Four-wire coil sequence by position mod 4
    function automatic logic [COIL_WIDTH-1:0] four_wire_coils(input logic [1:0] q);
        logic [COIL_WIDTH-1:0] c;
        case (q)
            2'd0:    c = 4'd5;
            2'd1:    c = 4'd6;
            2'd2:    c = 4'd10;
            default: c = 4'd9;
        endcase
        return c;
    endfunction

endpackage

// ===== src/sss_step_logic.sv =====
// Next-state and result logic for one item of the stepper step sequencer.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_step_logic
(
    input  sss_pkg::state_t                       state_cur,
    input  sss_pkg::cfg_t                         cfg,
    input  logic                                  action,
    input  logic signed [sss_pkg::MOVE_WIDTH-1:0] move_steps,
    output sss_pkg::state_t                       state_nxt,
    output sss_pkg::result_t                      result
);

    logic                             neg;
    logic [sss_pkg::MOVE_WIDTH-1:0]   mag;
    logic                             mag_sat;
    logic [sss_pkg::TIMER_WIDTH-1:0]  elapsed_inc;
    logic                             period_hit;
    logic                             take_step;
    logic [sss_pkg::POS_WIDTH-1:0]    pos_fwd;
    logic [sss_pkg::POS_WIDTH-1:0]    pos_rev_base;
    logic [sss_pkg::POS_WIDTH-1:0]    pos_step;
    logic                             done;

    // Magnitude of a load, saturated to the count width
    assign neg     = move_steps[sss_pkg::MOVE_WIDTH-1];
    assign mag     = neg ? (~move_steps + 1'b1) : move_steps;
    assign mag_sat = mag > sss_pkg::MOVE_WIDTH'(sss_pkg::COUNT_MAX);

    // Saturating timer and period compare
    assign elapsed_inc = (state_cur.elapsed == sss_pkg::TIMER_MAX) ?
                         state_cur.elapsed : state_cur.elapsed + 1'b1;
    assign period_hit  = 33'(elapsed_inc) >= 33'(cfg.step_period);
    assign take_step   = (action == sss_pkg::ACT_TICK) && (state_cur.remaining != '0)
                         && period_hit;

    // Position one step on, wrapping at steps_per_rev
    assign pos_fwd      = state_cur.position + 1'b1;
    assign pos_rev_base = (state_cur.position == '0) ? cfg.steps_per_rev
                                                     : state_cur.position;
    always_comb
    begin
        if (state_cur.direction)
            pos_step = (pos_fwd == cfg.steps_per_rev) ? '0 : pos_fwd;
        else
            pos_step = pos_rev_base - 1'b1;
    end

    // State update
    always_comb
    begin
        state_nxt = state_cur;
        done      = 1'b0;
        if (action == sss_pkg::ACT_LOAD)
        begin
            state_nxt.remaining = mag_sat ? sss_pkg::COUNT_MAX
                                          : mag[sss_pkg::COUNT_WIDTH-1:0];
            if (neg)
                state_nxt.direction = 1'b0;
            else if (move_steps != '0)
                state_nxt.direction = 1'b1;
        end
        else
        begin
            state_nxt.elapsed = elapsed_inc;
            if (state_cur.remaining != '0)
            begin
                state_nxt.was_running = 1'b1;
                if (take_step)
                begin
                    state_nxt.position  = pos_step;
                    state_nxt.remaining = state_cur.remaining - 1'b1;
                    state_nxt.elapsed   = '0;
                    unique case (cfg.drive_mode)
                        sss_pkg::MODE_DRIVER:    state_nxt.dir_line = state_cur.direction;
                        sss_pkg::MODE_TWO_WIRE:  state_nxt.coils =
                                                     sss_pkg::two_wire_coils(pos_step[1:0]);
                        sss_pkg::MODE_FOUR_WIRE: state_nxt.coils =
                                                     sss_pkg::four_wire_coils(pos_step[1:0]);
                        default:                 state_nxt.coils = state_cur.coils;
                    endcase
                end
            end
            else
            begin
                done                  = state_cur.was_running;
                state_nxt.was_running = 1'b0;
            end
        end
    end

    // Result fields come from the updated state; step_pulse and done_res come from this update
    always_comb
    begin
        result.coil_lines = state_nxt.coils;
        result.dir_line   = state_nxt.dir_line;
        result.step_pulse = take_step;
        result.done_res   = done;
        result.busy_res   = state_nxt.remaining != '0;
        result.position   = state_nxt.position;
    end

endmodule

// ===== src/stepper_step_sequencer.sv =====
// Top level of the stepper step sequencer: input register, state, config, output register.
// Depends on sss_pkg and sss_step_logic.
`timescale 1ns / 1ps

// Channel   Dir  Fields (lowest bit first)
// s_*       in   tuser: action; tdata: move_steps[31:0]
// m_*       out  tdata: coil_lines[3:0], dir_line, step_pulse, done_res, busy_res,
//                       position[15:0]
// cfg_*     in   cfg_index selects step_period / steps_per_rev / drive_mode
//
// One item per cycle while the output is not stalled: a transfer lands in the
// input register, then the state is updated and the result written to the
// output register.
// A stalled output holds the input register; s_tready drops only when both
// the input and output registers are full and m_tready is low.
// Reset clears the motion state and loads the register reset values.

module stepper_step_sequencer
(
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic                                     s_tuser,   // action
    input  logic signed [sss_pkg::MOVE_WIDTH-1:0]    s_tdata,   // move_steps

    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // coil_lines[3:0], dir_line, step_pulse, done_res, busy_res, position[15:0]
    output logic [sss_pkg::OUT_WIDTH-1:0]            m_tdata,

    input  logic                                     cfg_we,
    input  logic [sss_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
    input  logic [sss_pkg::CFG_DATA_WIDTH-1:0]       cfg_data
);

    sss_pkg::cfg_t                          cfg_reg;
    sss_pkg::state_t                        state_reg;
    sss_pkg::state_t                        state_next;
    sss_pkg::result_t                       result;

    logic                                   in_valid_reg;
    logic                                   in_action_reg;
    logic signed [sss_pkg::MOVE_WIDTH-1:0]  in_steps_reg;
    logic                                   out_valid_reg;
    logic [sss_pkg::OUT_WIDTH-1:0]          out_data_reg;
    logic                                   advance;

    // Handshake: process when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_period   <= '0;
            cfg_reg.steps_per_rev <= sss_pkg::SPR_RESET;
            cfg_reg.drive_mode    <= sss_pkg::MODE_DRIVER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sss_pkg::CFG_STEP_PERIOD:
                    cfg_reg.step_period   <= cfg_data[sss_pkg::PERIOD_WIDTH-1:0];
                sss_pkg::CFG_STEPS_PER_REV:
                    cfg_reg.steps_per_rev <= cfg_data[sss_pkg::POS_WIDTH-1:0];
                sss_pkg::CFG_DRIVE_MODE:
                    cfg_reg.drive_mode    <= cfg_data[sss_pkg::MODE_WIDTH-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_steps_reg  <= s_tdata;
        end
    end

    // Per-item step logic
    sss_step_logic u_step
    (
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .action     (in_action_reg),
        .move_steps (in_steps_reg),
        .state_nxt  (state_next),
        .result     (result)
    );

    // Motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

endmodule

// ===== dv/sss_motion_checker.sv =====
// Scoreboard for the stepper step sequencer: tracks config writes, predicts one
// result per input transfer and compares every output transfer field by field.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_motion_checker
    import sss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      s_tuser,    // action
    input  logic [MOVE_WIDTH-1:0]     s_tdata,    // move_steps

    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // coil_lines[3:0], dir_line, step_pulse, done_res, busy_res, position[15:0]
    input  logic [OUT_WIDTH-1:0]      m_tdata,

    input  logic                      cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,

    output int                        fail_count,
    output int                        pending
);

    // Coil patterns by position mod 4, entry 0 in the low nibble
    localparam logic [15:0] TWO_WIRE_SEQ  = {4'd0, 4'd1, 4'd3, 4'd2};
    localparam logic [15:0] FOUR_WIRE_SEQ = {4'd9, 4'd10, 4'd6, 4'd5};

    // Register copies
    logic [PERIOD_WIDTH-1:0] period;
    logic [POS_WIDTH-1:0]    rev_len;
    logic [MODE_WIDTH-1:0]   mode;

    // Motion state
    logic [TIMER_WIDTH-1:0]  elapsed;
    logic [COUNT_WIDTH-1:0]  remaining;
    logic [POS_WIDTH-1:0]    position;
    logic                    heading;      // 1 forward, 0 reverse
    logic                    was_running;
    logic [COIL_WIDTH-1:0]   coils;
    logic                    dir_reg;

    result_t expected_motion[$];
    int      errors;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // One item through the motion state; returns the result it produces
    function automatic result_t advance_motion(input logic act,
                                               input logic [MOVE_WIDTH-1:0] mv);
        result_t                 r;
        logic [MOVE_WIDTH-1:0]   mag;
        logic [1:0]              q;
        r = '0;
        if (act == ACT_LOAD)
        begin
            // magnitude and heading; a zero move keeps the old heading
            if (mv[MOVE_WIDTH-1])
            begin
                mag     = -mv;
                heading = 1'b0;
            end
            else
            begin
                mag = mv;
                if (mv != '0)
                    heading = 1'b1;
            end
            remaining = (mag > {1'b0, COUNT_MAX}) ? COUNT_MAX : mag[COUNT_WIDTH-1:0];
        end
        else
        begin
            if (elapsed != TIMER_MAX)
                elapsed = elapsed + 1'b1;
            if (remaining != '0)
            begin
                if (elapsed >= period)
                begin
                    // wrap test is equality, so positions past the wrap run on
                    if (heading)
                    begin
                        position = position + 16'd1;
                        if (position == rev_len)
                            position = '0;
                    end
                    else
                    begin
                        if (position == '0)
                            position = rev_len;
                        position = position - 16'd1;
                    end
                    remaining = remaining - 1'b1;
                    elapsed   = '0;
                    q         = position[1:0];
                    case (mode)
                        MODE_DRIVER:    dir_reg = heading;
                        MODE_TWO_WIRE:  coils   = TWO_WIRE_SEQ[q*4 +: 4];
                        MODE_FOUR_WIRE: coils   = FOUR_WIRE_SEQ[q*4 +: 4];
                        default:        ;   // spare mode: outputs hold
                    endcase
                    r.step_pulse = 1'b1;
                end
                was_running = 1'b1;
            end
            else
            begin
                r.done_res  = was_running;
                was_running = 1'b0;
            end
        end
        r.coil_lines = coils;
        r.dir_line   = dir_reg;
        r.busy_res   = (remaining != '0);
        r.position   = position;
        return r;
    endfunction

    // Watch the config port and both channels
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            period      = '0;
            rev_len     = SPR_RESET;
            mode        = MODE_DRIVER;
            elapsed     = '0;
            remaining   = '0;
            position    = '0;
            heading     = 1'b0;
            was_running = 1'b0;
            coils       = '0;
            dir_reg     = 1'b0;
            errors      = 0;
            expected_motion.delete();
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_PERIOD:   period  = cfg_data[PERIOD_WIDTH-1:0];
                    CFG_STEPS_PER_REV: rev_len = cfg_data[POS_WIDTH-1:0];
                    CFG_DRIVE_MODE:    mode    = cfg_data[MODE_WIDTH-1:0];
                    default:           ;
                endcase
            end

            // output transfer against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_motion.size() == 0)
                    report_mismatch("result with nothing expected", int'(got), 0);
                else
                begin
                    want = expected_motion.pop_front();
                    if (got.coil_lines != want.coil_lines)
                        report_mismatch("coil_lines", int'(got.coil_lines),
                                        int'(want.coil_lines));
                    if (got.dir_line != want.dir_line)
                        report_mismatch("dir_line", int'(got.dir_line),
                                        int'(want.dir_line));
                    if (got.step_pulse != want.step_pulse)
                        report_mismatch("step_pulse", int'(got.step_pulse),
                                        int'(want.step_pulse));
                    if (got.done_res != want.done_res)
                        report_mismatch("done_res", int'(got.done_res),
                                        int'(want.done_res));
                    if (got.busy_res != want.busy_res)
                        report_mismatch("busy_res", int'(got.busy_res),
                                        int'(want.busy_res));
                    if (got.position != want.position)
                        report_mismatch("position", int'(got.position),
                                        int'(want.position));
                end
            end

            // input transfer: predict its result
            if (s_tvalid && s_tready)
                expected_motion.push_back(advance_motion(s_tuser, s_tdata));

            fail_count <= errors;
            pending    <= expected_motion.size();
        end
    end

endmodule

// ===== dv/stepper_step_sequencer_test.sv =====
// Testbench top for the stepper step sequencer: clock, reset, config writes,
// load/tick stimulus with random idling, and the verdict.
// Depends on sss_pkg, stepper_step_sequencer and sss_motion_checker.
`timescale 1ns / 1ps

module stepper_step_sequencer_test;
    import sss_pkg::*;

    // Spare drive mode: steps are taken but coil and direction lines hold
    localparam logic [MODE_WIDTH-1:0] MODE_HOLD = 2'd3;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic                      s_tuser   = ACT_TICK;
    logic [MOVE_WIDTH-1:0]     s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_WIDTH-1:0]      m_tdata;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = CFG_STEP_PERIOD;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_off_req  = 1'b0;
    logic [PERIOD_WIDTH-1:0] cur_period = '0;

    stepper_step_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sss_motion_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // One input transfer, after a random number of idle cycles
    task automatic send_item(input logic act, input logic [MOVE_WIDTH-1:0] mv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= mv;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write all three registers; unused upper data bits carry junk
    task automatic apply_setup(input logic [PERIOD_WIDTH-1:0] per,
                               input logic [POS_WIDTH-1:0] rev,
                               input logic [MODE_WIDTH-1:0] md);
        logic [CFG_DATA_WIDTH-1:0] junk;
        junk       = CFG_DATA_WIDTH'($urandom());
        cur_period = per;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEP_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        cfg_index <= CFG_STEPS_PER_REV;
        cfg_data  <= {junk[CFG_DATA_WIDTH-1:POS_WIDTH], rev};
        @(posedge clk);
        cfg_index <= CFG_DRIVE_MODE;
        cfg_data  <= {junk[CFG_DATA_WIDTH-1:MODE_WIDTH], md};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly short moves either way, some full-range and boundary values
    function automatic logic [MOVE_WIDTH-1:0] pick_move();
        int unsigned r;
        logic [MOVE_WIDTH-1:0] mag;
        r = $urandom_range(99);
        if (r < 8)
            return $urandom();
        if (r < 12)
        begin
            case ($urandom_range(2))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                default: return 32'h8000_0001;
            endcase
        end
        mag = $urandom_range(12);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Load a move, then tick long enough to finish it; some runs get cut short
    task automatic run_moves(input int budget);
        int sent;
        int ticks;
        logic [MOVE_WIDTH-1:0] mv;
        logic [MOVE_WIDTH-1:0] mag;
        sent = 0;
        while (sent < budget)
        begin
            mv  = pick_move();
            mag = mv[MOVE_WIDTH-1] ? -mv : mv;
            send_item(ACT_LOAD, mv);
            sent++;
            if ($urandom_range(9) == 0)
                ticks = $urandom_range(3);
            else if (mag > 12 || cur_period > 10)
                ticks = $urandom_range(1, 40);
            else
                ticks = mag * (cur_period + 1) + $urandom_range(1, 4);
            repeat (ticks)
            begin
                send_item(ACT_TICK, $urandom());
                sent++;
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idles, receiver mostly stalls
        src_idle_pct  = 8;
        sink_idle_pct = 77;

        // directed part at reset settings: period 0, 200 steps, driver mode
        send_item(ACT_TICK, 32'hFFFF_FFFF);     // tick with no run pending
        send_item(ACT_LOAD, 32'd0);             // zero move keeps direction
        send_item(ACT_LOAD, 32'd3);
        repeat (4) send_item(ACT_TICK, 32'd0);  // three steps, then done
        send_item(ACT_LOAD, 32'hFFFF_FFFE);     // two steps in reverse
        repeat (3) send_item(ACT_TICK, $urandom()); // two reverse steps, then done
        send_item(ACT_LOAD, 32'h8000_0000);     // most negative saturates
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_LOAD, 32'h7FFF_FFFF);     // largest forward move
        send_item(ACT_TICK, 32'd0);
        send_item(ACT_LOAD, 32'd0);             // abort the run
        send_item(ACT_TICK, 32'd0);             // done after abort
        send_item(ACT_TICK, 32'd0);
        drain();

        // two-wire coils, short revolution
        apply_setup(26'd1, 16'd7, MODE_TWO_WIRE);
        run_moves(85);
        drain();
        // revolution length zero: wrap at the 16-bit limit
        apply_setup(26'd3, 16'd0, MODE_FOUR_WIRE);
        run_moves(85);
        drain();
        // spare mode, longest revolution
        apply_setup(26'd0, 16'd65535, MODE_HOLD);
        run_moves(85);
        drain();

        // now the sender idles and the receiver rarely does
        src_idle_pct  = 77;
        sink_idle_pct = 8;
        // one-step revolution, position most likely far past it
        apply_setup(26'd2, 16'd1, MODE_DRIVER);
        run_moves(85);
        drain();
        // longest period: timer never reaches it here
        apply_setup(26'h3FF_FFFF, 16'd13, MODE_TWO_WIRE);
        run_moves(30);
        drain();
        apply_setup(26'd0, 16'd5, MODE_FOUR_WIRE);
        run_moves(85);
        drain();

        // no idling, and one long receiver hold-off to fill the pipe
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        apply_setup(26'd1, 16'd3, MODE_DRIVER);
        hold_off_req = 1'b1;
        run_moves(85);
        drain();
        repeat (2)
        begin
            apply_setup(PERIOD_WIDTH'($urandom_range(4)),
                        POS_WIDTH'($urandom_range(1, 40)),
                        MODE_WIDTH'($urandom_range(3)));
            run_moves(85);
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
